[src/uets_pkg.sv]
package uets_pkg;

    // width of the max packet register and of packet lengths
    localparam int PKT_W = 10;

    // width of the fixed length fields on the ports
    localparam int PORT_LEN_W = 16;

    // action codes
    localparam logic [2:0] ACT_START_TX   = 3'd0;
    localparam logic [2:0] ACT_START_RX   = 3'd1;
    localparam logic [2:0] ACT_IN_DONE    = 3'd2;
    localparam logic [2:0] ACT_OUT_DONE   = 3'd3;
    localparam logic [2:0] ACT_SET_TOGGLE = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_QUEUE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // pipe indexes
    localparam logic PIPE_RX = 1'b0;
    localparam logic PIPE_TX = 1'b1;

    // status of the remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

[src/uets_rem_unit.sv]
module uets_rem_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [LENGTH_BITS-1:0]        dividend,
    input  logic [uets_pkg::PKT_W-1:0]    divisor,
    output uets_pkg::rem_status_t         status
);

    localparam int CNT_W = $clog2(LENGTH_BITS + 1);
    localparam int W     = uets_pkg::PKT_W;

    logic [W-1:0]           rem_reg, rem_next;
    logic [LENGTH_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg, done_next;
    logic [W:0]             trial;
    logic [W:0]             diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[LENGTH_BITS-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        done_next  = done_reg;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            count_next = CNT_W'(LENGTH_BITS);
            done_next  = 1'b0;
        end
        else if (count_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = diff[W-1:0];
            else
                rem_next = trial[W-1:0];
            quo_next   = {quo_reg[LENGTH_BITS-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            quo_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

[src/usb_endpoint_transfer_segmenter.sv]
// channel   signals                                  direction
// item      item_valid, item_stall, action .. toggle  beat in
// result    result_valid, result_stall, kind .. done  beat out
// config    max_packet_write, max_packet_data         write only
//
// start_tx steps: capture, one remainder bit a cycle of the clipped length by
// max_packet in the remainder unit, a check that it has finished, then emit.
// every other action is captured, then updated and emitted.
// an item is taken only when the sequencer is idle; a finished result waits
// in the output register while the next item is captured.
// asynchronous active-low reset clears all pipe state, max_packet goes to 64.
module usb_endpoint_transfer_segmenter #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        max_packet_write,
    input  logic [9:0]  max_packet_data,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  action,
    input  logic [15:0] length,
    input  logic [15:0] request_length,
    input  logic [9:0]  received_length,
    input  logic        pipe_select,
    input  logic        toggle_value,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic        pipe_dir,
    output logic [15:0] offset,
    output logic [9:0]  packet_length,
    output logic        data_toggle,
    output logic        bank,
    output logic [15:0] done_length
);

    localparam int L  = LENGTH_BITS;
    localparam int PW = uets_pkg::PKT_W;
    localparam int CW = (L > PW) ? L : PW;
    localparam int OW = uets_pkg::PORT_LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] max_packet_reg;

    // captured item
    logic [2:0]    action_reg;
    logic [L-1:0]  len_reg;
    logic [L-1:0]  req_reg;
    logic [PW-1:0] rcv_reg;
    logic          psel_reg;
    logic          tval_reg;

    // pipe state, index 0 receive, 1 transmit
    logic [1:0]    toggle_reg, toggle_next;
    logic [1:0]    bank_reg, bank_next;
    logic [L-1:0]  off_rx_reg, off_rx_next;
    logic [L-1:0]  off_tx_reg, off_tx_next;
    logic [L-1:0]  rem_rx_reg, rem_rx_next;
    logic [L-1:0]  rem_tx_reg, rem_tx_next;
    logic          zlp_reg, zlp_next;

    // output register
    logic          result_valid_reg, result_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic          pipe_reg, pipe_next;
    logic [L-1:0]  off_out_reg, off_out_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic          dtog_reg, dtog_next;
    logic          bank_out_reg, bank_out_next;
    logic [L-1:0]  done_reg, done_next;

    logic          accept;
    logic          emit_ok;
    logic [PW-1:0] mp;
    logic [L-1:0]  in_len;
    logic [L-1:0]  in_req;
    logic [L-1:0]  in_clip;
    logic [L-1:0]  clip_reg;

    logic [L-1:0]  tx_rem;
    logic [L-1:0]  tx_off;
    logic          tx_zlp;
    logic          tx_tog;
    logic [CW-1:0] tx_chunk;
    logic [CW-1:0] rx_first;
    logic [L-1:0]  rx_rem_new;
    logic [L-1:0]  rx_off_new;
    logic [CW-1:0] rx_chunk;

    uets_pkg::rem_status_t rem_status;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign emit_ok    = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);
    assign mp         = (max_packet_reg == '0) ? PW'(1) : max_packet_reg;

    // clip the transmit length to the host request at capture
    assign in_len  = L'(length);
    assign in_req  = L'(request_length);
    assign in_clip = (in_len > in_req) ? in_req : in_len;

    uets_rem_unit #(
        .LENGTH_BITS (L)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (action == uets_pkg::ACT_START_TX)),
        .dividend (in_clip),
        .divisor  (mp),
        .status   (rem_status)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (action == uets_pkg::ACT_START_TX) ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                if (rem_status.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_ok)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // transmit pipe view for the next IN packet
    always_comb
    begin
        if (action_reg == uets_pkg::ACT_START_TX)
        begin
            tx_rem = clip_reg;
            tx_off = '0;
            tx_zlp = (clip_reg < req_reg) && rem_status.zero;
            tx_tog = toggle_reg[1];
        end
        else
        begin
            tx_rem = rem_tx_reg;
            tx_off = off_tx_reg;
            tx_zlp = zlp_reg;
            tx_tog = ~toggle_reg[1];
        end
        tx_chunk = (CW'(tx_rem) < CW'(mp)) ? CW'(tx_rem) : CW'(mp);
    end

    // receive pipe arithmetic
    assign rx_first   = (CW'(len_reg) < CW'(mp)) ? CW'(len_reg) : CW'(mp);
    assign rx_rem_new = (CW'(rcv_reg) >= CW'(rem_rx_reg)) ? '0 : (rem_rx_reg - L'(rcv_reg));
    assign rx_off_new = off_rx_reg + L'(rcv_reg);
    assign rx_chunk   = (CW'(rx_rem_new) < CW'(mp)) ? CW'(rx_rem_new) : CW'(mp);

    // state update and result
    always_comb
    begin
        toggle_next   = toggle_reg;
        bank_next     = bank_reg;
        off_rx_next   = off_rx_reg;
        off_tx_next   = off_tx_reg;
        rem_rx_next   = rem_rx_reg;
        rem_tx_next   = rem_tx_reg;
        zlp_next      = zlp_reg;
        kind_next     = kind_reg;
        pipe_next     = pipe_reg;
        off_out_next  = off_out_reg;
        plen_next     = plen_reg;
        dtog_next     = dtog_reg;
        bank_out_next = bank_out_reg;
        done_next     = done_reg;

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;

        if (emit_ok)
        begin
            result_valid_next = 1'b1;
            kind_next         = uets_pkg::KIND_NONE;
            pipe_next         = uets_pkg::PIPE_RX;
            off_out_next      = '0;
            plen_next         = '0;
            bank_out_next     = 1'b0;
            done_next         = '0;
            dtog_next         = toggle_reg[0];
            case (action_reg)
                uets_pkg::ACT_START_TX, uets_pkg::ACT_IN_DONE:
                begin
                    toggle_next[1] = tx_tog;
                    pipe_next      = uets_pkg::PIPE_TX;
                    dtog_next      = tx_tog;
                    off_tx_next    = tx_off;
                    rem_tx_next    = tx_rem;
                    zlp_next       = tx_zlp;
                    if (tx_rem != '0)
                    begin
                        off_tx_next   = tx_off + L'(tx_chunk);
                        rem_tx_next   = tx_rem - L'(tx_chunk);
                        bank_next[1]  = ~bank_reg[1];
                        kind_next     = uets_pkg::KIND_QUEUE;
                        off_out_next  = tx_off;
                        plen_next     = PW'(tx_chunk);
                        bank_out_next = bank_reg[1];
                    end
                    else if (tx_zlp)
                    begin
                        zlp_next      = 1'b0;
                        bank_next[1]  = ~bank_reg[1];
                        kind_next     = uets_pkg::KIND_QUEUE;
                        off_out_next  = tx_off;
                        bank_out_next = bank_reg[1];
                    end
                    else
                    begin
                        kind_next = uets_pkg::KIND_DONE;
                    end
                end
                uets_pkg::ACT_START_RX:
                begin
                    rem_rx_next   = len_reg;
                    off_rx_next   = '0;
                    kind_next     = uets_pkg::KIND_QUEUE;
                    plen_next     = PW'(rx_first);
                    bank_out_next = bank_reg[0];
                end
                uets_pkg::ACT_OUT_DONE:
                begin
                    toggle_next[0] = ~toggle_reg[0];
                    bank_next[0]   = ~bank_reg[0];
                    rem_rx_next    = rx_rem_new;
                    off_rx_next    = rx_off_new;
                    dtog_next      = ~toggle_reg[0];
                    if ((rcv_reg < mp) || (rx_rem_new == '0))
                    begin
                        kind_next = uets_pkg::KIND_DONE;
                        done_next = rx_off_new;
                    end
                    else
                    begin
                        kind_next     = uets_pkg::KIND_QUEUE;
                        off_out_next  = rx_off_new;
                        plen_next     = PW'(rx_chunk);
                        bank_out_next = ~bank_reg[0];
                    end
                end
                uets_pkg::ACT_SET_TOGGLE:
                begin
                    toggle_next[psel_reg] = tval_reg;
                    pipe_next             = psel_reg;
                    dtog_next             = tval_reg;
                end
                default:
                begin
                    kind_next = uets_pkg::KIND_NONE;
                end
            endcase
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_packet_reg <= PW'(64);
        else if (max_packet_write)
            max_packet_reg <= max_packet_data;
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            len_reg    <= in_len;
            req_reg    <= in_req;
            clip_reg   <= in_clip;
            rcv_reg    <= received_length;
            psel_reg   <= pipe_select;
            tval_reg   <= toggle_value;
        end
    end

    // control, pipe state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            toggle_reg       <= '0;
            bank_reg         <= '0;
            off_rx_reg       <= '0;
            off_tx_reg       <= '0;
            rem_rx_reg       <= '0;
            rem_tx_reg       <= '0;
            zlp_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            toggle_reg       <= toggle_next;
            bank_reg         <= bank_next;
            off_rx_reg       <= off_rx_next;
            off_tx_reg       <= off_tx_next;
            rem_rx_reg       <= rem_rx_next;
            rem_tx_reg       <= rem_tx_next;
            zlp_reg          <= zlp_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pipe_reg     <= pipe_next;
        off_out_reg  <= off_out_next;
        plen_reg     <= plen_next;
        dtog_reg     <= dtog_next;
        bank_out_reg <= bank_out_next;
        done_reg     <= done_next;
    end

    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign pipe_dir      = pipe_reg;
    assign offset        = OW'(off_out_reg);
    assign packet_length = plen_reg;
    assign data_toggle   = dtog_reg;
    assign bank          = bank_out_reg;
    assign done_length   = OW'(done_reg);

endmodule

[verif/uets_checker.sv]
`timescale 1ns / 1ps

module uets_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        max_packet_write,
    input  logic [9:0]  max_packet_data,

    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [2:0]  action,
    input  logic [15:0] length,
    input  logic [15:0] request_length,
    input  logic [9:0]  received_length,
    input  logic        pipe_select,
    input  logic        toggle_value,

    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic        pipe_dir,
    input  logic [15:0] offset,
    input  logic [9:0]  packet_length,
    input  logic        data_toggle,
    input  logic        bank,
    input  logic [15:0] done_length,

    output int          mismatch_count,
    output int          outstanding_count
);

    localparam logic [9:0] MAX_PACKET_RESET = 10'd64;
    localparam int         REPORT_LIMIT     = 10;

    // one result beat as the segmenter should produce it
    typedef struct packed {
        logic [1:0]  kind;
        logic        pipe;
        logic [15:0] offset;
        logic [9:0]  plen;
        logic        toggle;
        logic        bank;
        logic [15:0] done_len;
    } segment_result_t;

    // shadow endpoint state, index 0 receive pipe, 1 transmit pipe
    logic [9:0]      packet_limit;
    logic            toggle_q [2];
    logic            bank_q [2];
    logic [15:0]     offset_q [2];
    logic [15:0]     remain_q [2];
    logic            zlp_armed;

    segment_result_t expected_q [$];
    segment_result_t oldest;
    segment_result_t observed;
    int              failures;

    // a packet size of zero behaves as one
    function automatic logic [15:0] usable_packet_size();
        return (packet_limit == 10'd0) ? 16'd1 : {6'd0, packet_limit};
    endfunction

    function automatic segment_result_t make_result(input logic [1:0] k, input logic pipe,
                                                    input logic [15:0] off,
                                                    input logic [9:0] plen, input logic bnk,
                                                    input logic [15:0] done_len);
        segment_result_t r;
        r.kind     = k;
        r.pipe     = pipe;
        r.offset   = off;
        r.plen     = plen;
        r.toggle   = toggle_q[pipe];
        r.bank     = bnk;
        r.done_len = done_len;
        return r;
    endfunction

    // next IN packet: data chunk, then armed zlp, then completion
    function automatic segment_result_t advance_tx_pipe();
        logic [15:0] mp;
        logic [15:0] chunk;
        logic [15:0] off;
        logic        bnk;
        mp = usable_packet_size();
        toggle_q[uets_pkg::PIPE_TX] = ~toggle_q[uets_pkg::PIPE_TX];
        if (remain_q[uets_pkg::PIPE_TX] != 16'd0)
        begin
            chunk = (remain_q[uets_pkg::PIPE_TX] < mp) ? remain_q[uets_pkg::PIPE_TX] : mp;
            off = offset_q[uets_pkg::PIPE_TX];
            bnk = bank_q[uets_pkg::PIPE_TX];
            offset_q[uets_pkg::PIPE_TX] = offset_q[uets_pkg::PIPE_TX] + chunk;
            remain_q[uets_pkg::PIPE_TX] = remain_q[uets_pkg::PIPE_TX] - chunk;
            bank_q[uets_pkg::PIPE_TX] = ~bank_q[uets_pkg::PIPE_TX];
            return make_result(uets_pkg::KIND_QUEUE, uets_pkg::PIPE_TX, off, chunk[9:0], bnk,
                               16'd0);
        end
        if (zlp_armed)
        begin
            bnk = bank_q[uets_pkg::PIPE_TX];
            zlp_armed = 1'b0;
            bank_q[uets_pkg::PIPE_TX] = ~bank_q[uets_pkg::PIPE_TX];
            return make_result(uets_pkg::KIND_QUEUE, uets_pkg::PIPE_TX,
                               offset_q[uets_pkg::PIPE_TX], 10'd0, bnk, 16'd0);
        end
        return make_result(uets_pkg::KIND_DONE, uets_pkg::PIPE_TX, 16'd0, 10'd0, 1'b0, 16'd0);
    endfunction

    // expected result of one item beat, updating the shadow state
    function automatic segment_result_t predict_segment(input logic [2:0] act,
                                                        input logic [15:0] len,
                                                        input logic [15:0] req,
                                                        input logic [9:0] rcv,
                                                        input logic psel, input logic tval);
        logic [15:0]     mp;
        logic [15:0]     clip;
        logic [15:0]     rcv_wide;
        segment_result_t r;
        mp = usable_packet_size();
        rcv_wide = {6'd0, rcv};
        case (act)
            uets_pkg::ACT_START_TX:
            begin
                clip = (len > req) ? req : len;
                remain_q[uets_pkg::PIPE_TX] = clip;
                offset_q[uets_pkg::PIPE_TX] = 16'd0;
                zlp_armed = (clip < req) && ((clip % mp) == 16'd0);
                // pre-flip so the first packet keeps the current toggle
                toggle_q[uets_pkg::PIPE_TX] = ~toggle_q[uets_pkg::PIPE_TX];
                r = advance_tx_pipe();
            end
            uets_pkg::ACT_START_RX:
            begin
                clip = (len < mp) ? len : mp;
                remain_q[uets_pkg::PIPE_RX] = len;
                offset_q[uets_pkg::PIPE_RX] = 16'd0;
                r = make_result(uets_pkg::KIND_QUEUE, uets_pkg::PIPE_RX, 16'd0, clip[9:0],
                                bank_q[uets_pkg::PIPE_RX], 16'd0);
            end
            uets_pkg::ACT_IN_DONE:
            begin
                r = advance_tx_pipe();
            end
            uets_pkg::ACT_OUT_DONE:
            begin
                toggle_q[uets_pkg::PIPE_RX] = ~toggle_q[uets_pkg::PIPE_RX];
                // overrun saturates the remaining count at zero
                remain_q[uets_pkg::PIPE_RX] = (rcv_wide >= remain_q[uets_pkg::PIPE_RX]) ?
                                              16'd0 : remain_q[uets_pkg::PIPE_RX] - rcv_wide;
                offset_q[uets_pkg::PIPE_RX] = offset_q[uets_pkg::PIPE_RX] + rcv_wide;
                bank_q[uets_pkg::PIPE_RX] = ~bank_q[uets_pkg::PIPE_RX];
                if (rcv_wide < mp || remain_q[uets_pkg::PIPE_RX] == 16'd0)
                begin
                    r = make_result(uets_pkg::KIND_DONE, uets_pkg::PIPE_RX, 16'd0, 10'd0, 1'b0,
                                    offset_q[uets_pkg::PIPE_RX]);
                end
                else
                begin
                    clip = (remain_q[uets_pkg::PIPE_RX] < mp) ? remain_q[uets_pkg::PIPE_RX] : mp;
                    r = make_result(uets_pkg::KIND_QUEUE, uets_pkg::PIPE_RX,
                                    offset_q[uets_pkg::PIPE_RX], clip[9:0],
                                    bank_q[uets_pkg::PIPE_RX], 16'd0);
                end
            end
            uets_pkg::ACT_SET_TOGGLE:
            begin
                toggle_q[psel] = tval;
                r = make_result(uets_pkg::KIND_NONE, psel, 16'd0, 10'd0, 1'b0, 16'd0);
            end
            default:
            begin
                r = make_result(uets_pkg::KIND_NONE, uets_pkg::PIPE_RX, 16'd0, 10'd0, 1'b0,
                                16'd0);
            end
        endcase
        return r;
    endfunction

    function automatic string show(input segment_result_t r);
        return $sformatf("kind=%0d pipe=%0d offset=%0d len=%0d toggle=%0d bank=%0d done=%0d",
                         r.kind, r.pipe, r.offset, r.plen, r.toggle, r.bank, r.done_len);
    endfunction

    task automatic log_mismatch(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t segment mismatch: %s", $realtime, msg);
    endtask

    // score result beats first, then predict the item beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_limit = MAX_PACKET_RESET;
            for (int p = 0; p < 2; p++)
            begin
                toggle_q[p] = 1'b0;
                bank_q[p]   = 1'b0;
                offset_q[p] = 16'd0;
                remain_q[p] = 16'd0;
            end
            zlp_armed = 1'b0;
            expected_q.delete();
            failures = 0;
            mismatch_count <= 0;
            outstanding_count <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                observed = '{kind, pipe_dir, offset, packet_length, data_toggle, bank,
                             done_length};
                if (expected_q.size() == 0)
                begin
                    log_mismatch({"unexpected beat ", show(observed)});
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (observed !== oldest)
                        log_mismatch({"expected ", show(oldest), " got ", show(observed)});
                end
            end
            if (item_valid && !item_stall)
                expected_q.push_back(predict_segment(action, length, request_length,
                                                     received_length, pipe_select,
                                                     toggle_value));
            if (max_packet_write)
                packet_limit = max_packet_data;
            mismatch_count <= failures;
            outstanding_count <= expected_q.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 24;
    localparam int PHASE_ITEMS    = 210;
    localparam int ACK_CAP        = 70;

    logic        clk;
    logic        rst_n;
    logic        max_packet_write;
    logic [9:0]  max_packet_data;
    logic        item_valid;
    logic        item_stall;
    logic [2:0]  action;
    logic [15:0] length;
    logic [15:0] request_length;
    logic [9:0]  received_length;
    logic        pipe_select;
    logic        toggle_value;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic        pipe_dir;
    logic [15:0] offset;
    logic [9:0]  packet_length;
    logic        data_toggle;
    logic        bank;
    logic [15:0] done_length;

    int          mismatch_count;
    int          outstanding_count;
    int          items_sent;
    int          burst_left;
    int          packet_setting;
    int          quiet_cycles;
    logic [9:0]  packet_plan [7];

    usb_endpoint_transfer_segmenter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_packet_write (max_packet_write),
        .max_packet_data  (max_packet_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .action           (action),
        .length           (length),
        .request_length   (request_length),
        .received_length  (received_length),
        .pipe_select      (pipe_select),
        .toggle_value     (toggle_value),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .kind             (kind),
        .pipe_dir         (pipe_dir),
        .offset           (offset),
        .packet_length    (packet_length),
        .data_toggle      (data_toggle),
        .bank             (bank),
        .done_length      (done_length)
    );

    uets_checker segment_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_packet_write  (max_packet_write),
        .max_packet_data   (max_packet_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .action            (action),
        .length            (length),
        .request_length    (request_length),
        .received_length   (received_length),
        .pipe_select       (pipe_select),
        .toggle_value      (toggle_value),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .kind              (kind),
        .pipe_dir          (pipe_dir),
        .offset            (offset),
        .packet_length     (packet_length),
        .data_toggle       (data_toggle),
        .bank              (bank),
        .done_length       (done_length),
        .mismatch_count    (mismatch_count),
        .outstanding_count (outstanding_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL usb_endpoint_transfer_segmenter");
                $finish;
            end
        end
    end

    // result side stall: early light stalls, one long hold-off, then mixed patterns
    initial
    begin : stall_pattern
        int span;
        int mode;
        int period;
        int tick;
        result_stall <= 1'b0;
        tick = 0;
        do @(posedge clk); while (!rst_n);
        repeat (200)
        begin
            @(posedge clk);
            result_stall <= ($urandom_range(0, 3) == 0);
        end
        // long hold-off so the block backs up and stalls its input
        repeat (300)
        begin
            @(posedge clk);
            result_stall <= 1'b1;
        end
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            period = $urandom_range(2, 9);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((tick % period) < (period / 2));
                endcase
            end
        end
    end

    // offer one item beat, in bursts with random gaps, and wait for acceptance
    task automatic offer_item(input logic [2:0] act, input logic [15:0] len,
                              input logic [15:0] req, input logic [9:0] rcv,
                              input logic psel, input logic tval);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 2))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        item_valid      <= 1'b1;
        action          <= act;
        length          <= len;
        request_length  <= req;
        received_length <= rcv;
        pipe_select     <= psel;
        toggle_value    <= tval;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding_count != 0)
            @(posedge clk);
    endtask

    // new packet size, written only with the block idle
    task automatic set_packet_size(input logic [9:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        max_packet_write <= 1'b1;
        max_packet_data  <= value;
        @(posedge clk);
        max_packet_write <= 1'b0;
        packet_setting = int'(value);
    endtask

    function automatic int usable_size();
        return (packet_setting == 0) ? 1 : packet_setting;
    endfunction

    // transfer length, mostly a few packets long
    function automatic int pick_length(input int mp);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 65535);
            1: return mp * $urandom_range(0, 4);
            2: return 0;
            default: return $urandom_range(0, (mp * 5 > 65535) ? 65535 : mp * 5);
        endcase
    endfunction

    // IN transfer: start then completions, not always enough to reach zlp and completion
    task automatic run_tx_transfer();
        int mp;
        int total;
        int req;
        int clip;
        int acks;
        mp = usable_size();
        total = pick_length(mp);
        case ($urandom_range(0, 4))
            0: req = total;
            1: req = (total + 3 * mp > 65535) ? 65535 : total + $urandom_range(1, 3 * mp);
            2: req = $urandom_range(0, total);
            3: req = 65535;
            default: req = $urandom_range(0, 65535);
        endcase
        clip = (total < req) ? total : req;
        acks = (clip + mp - 1) / mp + $urandom_range(0, 2);
        if (acks > ACK_CAP)
            acks = $urandom_range(4, 20);
        offer_item(uets_pkg::ACT_START_TX, 16'(total), 16'(req), 10'($urandom),
                   1'($urandom), 1'($urandom));
        repeat (acks)
            offer_item(uets_pkg::ACT_IN_DONE, 16'($urandom), 16'($urandom), 10'($urandom),
                       1'($urandom), 1'($urandom));
    endtask

    // OUT transfer: mostly full packets, some short ones and some overruns
    task automatic run_rx_transfer(input int total, input bit full_only);
        int mp;
        int acks;
        int rcv;
        mp = usable_size();
        acks = total / mp + 1 + $urandom_range(0, 1);
        if (acks > ACK_CAP && !full_only)
            acks = $urandom_range(4, 20);
        offer_item(uets_pkg::ACT_START_RX, 16'(total), 16'($urandom), 10'($urandom),
                   1'($urandom), 1'($urandom));
        repeat (acks)
        begin
            case (full_only ? 2 : $urandom_range(0, 5))
                0: rcv = $urandom_range(0, mp - 1);
                1: rcv = $urandom_range(0, 1023);
                default: rcv = mp;
            endcase
            offer_item(uets_pkg::ACT_OUT_DONE, 16'($urandom), 16'($urandom), 10'(rcv),
                       1'($urandom), 1'($urandom));
        end
    endtask

    // mostly whole transfers, with toggle writes and raw noise between them
    task automatic run_mixed_traffic(input int target);
        int pick;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                run_tx_transfer();
            else if (pick < 16)
                run_rx_transfer(pick_length(usable_size()), 1'b0);
            else if (pick < 18)
                offer_item(uets_pkg::ACT_SET_TOGGLE, 16'($urandom), 16'($urandom),
                           10'($urandom), 1'($urandom), 1'($urandom));
            else
                offer_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                           10'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n            <= 1'b0;
        max_packet_write <= 1'b0;
        max_packet_data  <= 10'd0;
        item_valid       <= 1'b0;
        action           <= uets_pkg::ACT_START_TX;
        length           <= 16'd0;
        request_length   <= 16'd0;
        received_length  <= 10'd0;
        pipe_select      <= uets_pkg::PIPE_RX;
        toggle_value     <= 1'b0;
        items_sent = 0;
        burst_left = 0;
        packet_setting = 64;
        packet_plan[0] = 10'd1;
        packet_plan[1] = 10'd1023;
        packet_plan[2] = 10'd0;
        packet_plan[3] = 10'd8;
        packet_plan[4] = 10'($urandom_range(2, 1022));
        packet_plan[5] = 10'($urandom_range(2, 1022));
        packet_plan[6] = 10'd64;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty transfer, and zlp when the request is longer
        offer_item(uets_pkg::ACT_START_TX, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_START_TX, 16'd0, 16'd10, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_IN_DONE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        // exact multiple of the packet size short of the request arms a zlp
        offer_item(uets_pkg::ACT_START_TX, 16'd128, 16'd200, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        repeat (3)
            offer_item(uets_pkg::ACT_IN_DONE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        // largest lengths
        offer_item(uets_pkg::ACT_START_TX, 16'hFFFF, 16'hFFFF, 10'h3FF, uets_pkg::PIPE_TX,
                   1'b1);
        offer_item(uets_pkg::ACT_IN_DONE, 16'hFFFF, 16'hFFFF, 10'h3FF, uets_pkg::PIPE_TX,
                   1'b1);
        // clipped to the request, then completions running past the end
        offer_item(uets_pkg::ACT_START_TX, 16'd300, 16'd100, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        repeat (3)
            offer_item(uets_pkg::ACT_IN_DONE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        // receive: empty, largest, oversized packet, short packet, overrun
        offer_item(uets_pkg::ACT_START_RX, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_START_RX, 16'hFFFF, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_OUT_DONE, 16'd0, 16'd0, 10'h3FF, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_OUT_DONE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_START_RX, 16'd100, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b0);
        offer_item(uets_pkg::ACT_OUT_DONE, 16'd0, 16'd0, 10'h3FF, uets_pkg::PIPE_RX, 1'b0);
        // direct toggle writes on both pipes
        offer_item(uets_pkg::ACT_SET_TOGGLE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_RX, 1'b1);
        offer_item(uets_pkg::ACT_SET_TOGGLE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_TX, 1'b1);
        offer_item(uets_pkg::ACT_SET_TOGGLE, 16'd0, 16'd0, 10'd0, uets_pkg::PIPE_TX, 1'b0);
        // undefined action codes
        for (int a = int'(uets_pkg::ACT_SET_TOGGLE) + 1; a < 8; a++)
            offer_item(3'(a), 16'hFFFF, 16'hFFFF, 10'h3FF, uets_pkg::PIPE_TX, 1'b1);

        run_mixed_traffic(items_sent + PHASE_ITEMS);
        foreach (packet_plan[i])
        begin
            set_packet_size(packet_plan[i]);
            // full-length receive whose offset wraps past the top
            if (packet_plan[i] == 10'd1023)
                run_rx_transfer(65535, 1'b1);
            run_mixed_traffic(items_sent + PHASE_ITEMS);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding_count == 0)
            $display("PASS usb_endpoint_transfer_segmenter");
        else
            $display("FAIL usb_endpoint_transfer_segmenter");
        $finish;
    end

endmodule
